@@ rtl/amrc_pkg.sv @@
// amrc_pkg: shared types and constants of the accel minimum repetition counter
// no dependencies; imported by amrc_core and accel_minimum_rep_counter_unit
package amrc_pkg;

  localparam int Z_WIDTH         = 16;
  localparam int COUNT_WIDTH     = 32;
  localparam int CFG_TIME_WIDTH  = 32;
  localparam int THR_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int WIN_DEPTH       = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MINIMA_WINDOW     = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_CYCLE         = 8'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REBOUND_THRESHOLD = 8'd2;

  // configuration reset values
  localparam logic [CFG_TIME_WIDTH-1:0] MINIMA_WINDOW_RESET     = 32'd1200000;
  localparam logic [CFG_TIME_WIDTH-1:0] MIN_CYCLE_RESET         = 32'd1000000;
  localparam logic [THR_WIDTH-1:0]      REBOUND_THRESHOLD_RESET = 16'd4500;

  // window fill levels
  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_TWO   = 2'd2;
  localparam logic [1:0] FILL_FULL  = 2'd3;

  typedef struct packed {
    logic [CFG_TIME_WIDTH-1:0] minima_window_us;
    logic [CFG_TIME_WIDTH-1:0] min_cycle_us;
    logic [THR_WIDTH-1:0]      rebound_threshold;
  } cfg_t;

endpackage

@@ rtl/amrc_skid.sv @@
// amrc_skid: two-entry output buffer with registered valid/ready on both sides
// generic over payload width; no package dependency
module amrc_skid #(
  parameter int WIDTH = 97
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  // control: main stage refills from skid first, else from input
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= in_data;
      end
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

  // skid entry only fills behind a held main entry
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without main entry");

  // a stalled, full buffer takes no item
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> !$past(in_fire) && skid_valid)
    else $error("item taken while buffer full");

  // a stalled main entry keeps its data
  a_main_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

@@ rtl/amrc_core.sv @@
// amrc_core: sample window, candidate minimum tracking and repetition decision
// depends on amrc_pkg; state advances on each accepted item, result is combinational
module amrc_core #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  amrc_pkg::cfg_t                       cfg,
  input  logic                                 fire,
  input  logic [TIME_WIDTH-1:0]                timestamp_us,
  input  logic signed [amrc_pkg::Z_WIDTH-1:0]  accel_z,
  output logic                                 res_counted,
  output logic [amrc_pkg::COUNT_WIDTH-1:0]     res_rep_count,
  output logic [TIME_WIDTH-1:0]                res_cycle_time,
  output logic signed [amrc_pkg::Z_WIDTH-1:0]  res_min_z
);
  import amrc_pkg::*;

  // state
  logic [TIME_WIDTH-1:0]     win_time [WIN_DEPTH];
  logic signed [Z_WIDTH-1:0] win_z    [WIN_DEPTH];
  logic [1:0]                fill_level;
  logic                      has_candidate;
  logic [TIME_WIDTH-1:0]     candidate_time;
  logic signed [Z_WIDTH-1:0] candidate_z;
  logic signed [Z_WIDTH-1:0] peak_z;
  logic                      has_reference;
  logic [TIME_WIDTH-1:0]     reference_time;
  logic [COUNT_WIDTH-1:0]    total_reps;

  // next values
  logic [TIME_WIDTH-1:0]     win_time_next [WIN_DEPTH];
  logic signed [Z_WIDTH-1:0] win_z_next    [WIN_DEPTH];
  logic [1:0]                fill_level_next;
  logic                      has_candidate_next;
  logic [TIME_WIDTH-1:0]     candidate_time_next;
  logic signed [Z_WIDTH-1:0] candidate_z_next;
  logic signed [Z_WIDTH-1:0] peak_z_next;
  logic                      has_reference_next;
  logic [TIME_WIDTH-1:0]     reference_time_next;
  logic [COUNT_WIDTH-1:0]    total_reps_next;

  logic signed [Z_WIDTH-1:0] peak_raised;
  logic                      is_min;
  logic [TIME_WIDTH-1:0]     mid_time;
  logic signed [Z_WIDTH-1:0] mid_z;
  logic [TIME_WIDTH-1:0]     gap_candidate;
  logic                      in_window;
  logic signed [Z_WIDTH:0]   rise;
  logic                      weak_rise;
  logic [TIME_WIDTH-1:0]     cycle;
  logic                      long_cycle;
  logic [COUNT_WIDTH-1:0]    reps_inc;
  logic                      hit;

  // peak follows every sample while a candidate is held
  assign peak_raised = (has_candidate && (accel_z > peak_z)) ? accel_z : peak_z;

  // window fill then shift
  always_comb begin
    win_time_next = win_time;
    win_z_next    = win_z;
    unique case (fill_level)
      FILL_EMPTY: begin
        win_time_next[0] = timestamp_us;
        win_z_next[0]    = accel_z;
      end
      FILL_ONE: begin
        win_time_next[1] = timestamp_us;
        win_z_next[1]    = accel_z;
      end
      FILL_TWO: begin
        win_time_next[2] = timestamp_us;
        win_z_next[2]    = accel_z;
      end
      FILL_FULL: begin
        win_time_next[0] = win_time[1];
        win_z_next[0]    = win_z[1];
        win_time_next[1] = win_time[2];
        win_z_next[1]    = win_z[2];
        win_time_next[2] = timestamp_us;
        win_z_next[2]    = accel_z;
      end
    endcase
  end

  assign fill_level_next = (fill_level == FILL_FULL) ? FILL_FULL : fill_level + 2'd1;

  // local minimum test on the shifted window
  assign mid_time = win_time_next[1];
  assign mid_z    = win_z_next[1];
  assign is_min   = fill_level[1] && (mid_z <= win_z_next[0]) && (mid_z <= win_z_next[2]);

  // time gaps wrap at the time width
  assign gap_candidate = mid_time - candidate_time;
  assign in_window     = gap_candidate <= TIME_WIDTH'(cfg.minima_window_us);
  assign cycle         = candidate_time - reference_time;
  assign long_cycle    = cycle >= TIME_WIDTH'(cfg.min_cycle_us);

  // rebound of the peak above the candidate
  assign rise      = {peak_raised[Z_WIDTH-1], peak_raised}
                   - {candidate_z[Z_WIDTH-1], candidate_z};
  assign weak_rise = rise < $signed({1'b0, cfg.rebound_threshold});

  assign reps_inc = total_reps + COUNT_WIDTH'(1);

  // candidate handling
  always_comb begin
    has_candidate_next  = has_candidate;
    candidate_time_next = candidate_time;
    candidate_z_next    = candidate_z;
    peak_z_next         = peak_raised;
    has_reference_next  = has_reference;
    reference_time_next = reference_time;
    total_reps_next     = total_reps;
    hit                 = 1'b0;
    if (is_min) begin
      priority if (!has_candidate) begin
        has_candidate_next  = 1'b1;
        candidate_time_next = mid_time;
        candidate_z_next    = mid_z;
        peak_z_next         = mid_z;
      end else if (in_window) begin
        // deeper minimum replaces the candidate, peak kept
        if (mid_z < candidate_z) begin
          candidate_time_next = mid_time;
          candidate_z_next    = mid_z;
        end
      end else if (weak_rise) begin
        candidate_time_next = mid_time;
        candidate_z_next    = mid_z;
        peak_z_next         = mid_z;
      end else begin
        // closed candidate: count against the reference or set it
        if (has_reference) begin
          if (long_cycle) begin
            hit             = 1'b1;
            total_reps_next = reps_inc;
          end
        end else begin
          has_reference_next = 1'b1;
        end
        reference_time_next = candidate_time;
        candidate_time_next = mid_time;
        candidate_z_next    = mid_z;
        peak_z_next         = mid_z;
      end
    end
  end

  // result fields, zero when not counted
  assign res_counted    = hit;
  assign res_rep_count  = hit ? reps_inc : '0;
  assign res_cycle_time = hit ? cycle : '0;
  assign res_min_z      = hit ? candidate_z : '0;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level    <= FILL_EMPTY;
      has_candidate <= 1'b0;
      has_reference <= 1'b0;
      total_reps    <= '0;
    end else if (fire) begin
      fill_level    <= fill_level_next;
      has_candidate <= has_candidate_next;
      has_reference <= has_reference_next;
      total_reps    <= total_reps_next;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    if (fire) begin
      win_time       <= win_time_next;
      win_z          <= win_z_next;
      candidate_time <= candidate_time_next;
      candidate_z    <= candidate_z_next;
      peak_z         <= peak_z_next;
      reference_time <= reference_time_next;
    end
  end

  // a reference only exists after a candidate
  a_ref_needs_cand: assert property (@(posedge clk) disable iff (rst)
    has_reference |-> has_candidate)
    else $error("reference without candidate");

  // candidates only appear once the window is full
  a_cand_needs_full: assert property (@(posedge clk) disable iff (rst)
    has_candidate |-> (fill_level == FILL_FULL))
    else $error("candidate before window full");

  // a counted item advances the total by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (fire && res_counted) |=> (total_reps == $past(total_reps) + COUNT_WIDTH'(1)))
    else $error("repetition total out of step");

  // counting needs an existing reference
  a_count_needs_ref: assert property (@(posedge clk) disable iff (rst)
    res_counted |-> has_reference)
    else $error("count without reference");

endmodule

@@ rtl/accel_minimum_rep_counter_unit.sv @@
// accel_minimum_rep_counter_unit: top level, configuration registers and output buffer
// depends on amrc_pkg, amrc_core and amrc_skid
//
// Counts up-down repetitions in timestamped vertical acceleration samples.
// Input channel (in_valid/in_ready): timestamp_us and accel_z, one sample per
// item. Output channel (out_valid/out_ready): exactly one result item per
// input item with counted, rep_count, cycle_time_us and min_z; all fields
// but counted are zero when counted is low.
// Configuration channel (cfg_valid/cfg_ready): cfg_index selects the minima
// window, the least cycle time or the rebound threshold; other indexes are
// ignored. cfg_ready is always high; write only while no item is in flight.
// Each result is registered in the output buffer. Throughput is one item per
// cycle while the buffer has room, set by the combinational window and
// candidate update in amrc_core. A two-entry output buffer keeps accepting while
// one result waits; with both entries held by a stalled receiver, in_ready drops.
// Reset (rst, synchronous) empties the window, drops the candidate and the
// reference, clears the total and loads the register defaults.
module accel_minimum_rep_counter_unit #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [TIME_WIDTH-1:0]                    timestamp_us,
  input  logic signed [amrc_pkg::Z_WIDTH-1:0]      accel_z,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     counted,
  output logic [amrc_pkg::COUNT_WIDTH-1:0]         rep_count,
  output logic [TIME_WIDTH-1:0]                    cycle_time_us,
  output logic signed [amrc_pkg::Z_WIDTH-1:0]      min_z,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [amrc_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [amrc_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);
  import amrc_pkg::*;

  localparam int RES_WIDTH = 1 + COUNT_WIDTH + TIME_WIDTH + Z_WIDTH;

  cfg_t                      cfg;
  logic                      fire;
  logic                      res_counted;
  logic [COUNT_WIDTH-1:0]    res_rep_count;
  logic [TIME_WIDTH-1:0]     res_cycle_time;
  logic signed [Z_WIDTH-1:0] res_min_z;
  logic [RES_WIDTH-1:0]      res_data;
  logic [RES_WIDTH-1:0]      out_data;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.minima_window_us  <= MINIMA_WINDOW_RESET;
      cfg.min_cycle_us      <= MIN_CYCLE_RESET;
      cfg.rebound_threshold <= REBOUND_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MINIMA_WINDOW:     cfg.minima_window_us  <= cfg_data;
        REG_MIN_CYCLE:         cfg.min_cycle_us      <= cfg_data;
        REG_REBOUND_THRESHOLD: cfg.rebound_threshold <= cfg_data[THR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // window, candidate and count logic
  amrc_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .fire          (fire),
    .timestamp_us  (timestamp_us),
    .accel_z       (accel_z),
    .res_counted   (res_counted),
    .res_rep_count (res_rep_count),
    .res_cycle_time(res_cycle_time),
    .res_min_z     (res_min_z)
  );

  assign res_data = {res_counted, res_rep_count, res_cycle_time, res_min_z};

  // result buffer
  amrc_skid #(
    .WIDTH(RES_WIDTH)
  ) u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (res_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign {counted, rep_count, cycle_time_us, min_z} = out_data;

endmodule

@@ dv/accel_minimum_rep_counter_unit_tb.sv @@
// accel_minimum_rep_counter_unit_tb: self-checking bench for the repetition counter unit
// drives samples and register writes, predicts every result item and checks it in order
// depends on amrc_pkg and accel_minimum_rep_counter_unit
module accel_minimum_rep_counter_unit_tb;
  import amrc_pkg::*;

  localparam int TW = 48;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 250;
  localparam int SETTLE_CYCLES = 4;

  // indexes that select no register
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NONE_FIRST = 8'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NONE_LAST  = 8'hFF;

  typedef struct {
    logic [TW-1:0]              stamp;
    logic signed [Z_WIDTH-1:0]  z;
  } sample_t;

  typedef struct {
    logic                         counted;
    logic [COUNT_WIDTH-1:0]       reps;
    logic [TW-1:0]                cycle;
    logic signed [Z_WIDTH-1:0]    minimum;
  } rep_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [TW-1:0]                 timestamp_us = '0;
  logic signed [Z_WIDTH-1:0]     accel_z = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          counted;
  logic [COUNT_WIDTH-1:0]        rep_count;
  logic [TW-1:0]                 cycle_time_us;
  logic signed [Z_WIDTH-1:0]     min_z;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]     cfg_data = '0;

  accel_minimum_rep_counter_unit #(.TIME_WIDTH(TW)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .timestamp_us(timestamp_us), .accel_z(accel_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .counted(counted), .rep_count(rep_count),
    .cycle_time_us(cycle_time_us), .min_z(min_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  sample_t     sample_queue[$];
  rep_result_t rep_expect[$];
  sample_t     next_sample;
  rep_result_t want;
  int          errors = 0;
  int          quiet = 0;
  bit          calm = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [TW-1:0] stamp = '0;

  // shadow of the configuration registers
  logic [CFG_TIME_WIDTH-1:0] window_us = MINIMA_WINDOW_RESET;
  logic [CFG_TIME_WIDTH-1:0] least_gap = MIN_CYCLE_RESET;
  logic [THR_WIDTH-1:0]      rebound   = REBOUND_THRESHOLD_RESET;

  // predictor state
  logic [TW-1:0]             win_t[WIN_DEPTH];
  logic signed [Z_WIDTH-1:0] win_z[WIN_DEPTH];
  logic [1:0]                fill = FILL_EMPTY;
  bit                        cand_valid = 1'b0;
  logic [TW-1:0]             cand_t = '0;
  logic signed [Z_WIDTH-1:0] cand_z = '0;
  logic signed [Z_WIDTH-1:0] peak = '0;
  bit                        ref_valid = 1'b0;
  logic [TW-1:0]             ref_t = '0;
  logic [COUNT_WIDTH-1:0]    total = '0;

  // advance the rep counter by one sample, return the result item it causes
  function automatic rep_result_t rep_predict(input logic [TW-1:0] t,
                                              input logic signed [Z_WIDTH-1:0] z);
    rep_result_t res;
    logic [TW-1:0] mt;
    logic [TW-1:0] span;
    logic [TW-1:0] gap;
    logic signed [Z_WIDTH-1:0] mz;
    res = '{1'b0, '0, '0, '0};
    if (cand_valid && z > peak) peak = z;
    if (fill != FILL_FULL) begin
      win_t[fill] = t;
      win_z[fill] = z;
      fill = fill + 2'd1;
      if (fill != FILL_FULL) return res;
    end else begin
      win_t[0] = win_t[1];
      win_z[0] = win_z[1];
      win_t[1] = win_t[2];
      win_z[1] = win_z[2];
      win_t[2] = t;
      win_z[2] = z;
    end
    if (win_z[1] <= win_z[0] && win_z[1] <= win_z[2]) begin
      mt = win_t[1];
      mz = win_z[1];
      span = mt - cand_t;
      if (!cand_valid) begin
        cand_valid = 1'b1;
        cand_t = mt;
        cand_z = mz;
        peak = mz;
      end else if (span <= {{(TW-CFG_TIME_WIDTH){1'b0}}, window_us}) begin
        // deeper minimum inside the window replaces the candidate
        if (mz < cand_z) begin
          cand_t = mt;
          cand_z = mz;
        end
      end else begin
        // candidate closes; it counts only after a big enough rebound
        if (int'(peak) - int'(cand_z) >= int'(rebound)) begin
          if (ref_valid) begin
            gap = cand_t - ref_t;
            if (gap >= {{(TW-CFG_TIME_WIDTH){1'b0}}, least_gap}) begin
              total = total + 1'b1;
              res = '{1'b1, total, gap, cand_z};
            end
          end else begin
            ref_valid = 1'b1;
          end
          ref_t = cand_t;
        end
        cand_t = mt;
        cand_z = mz;
        peak = mz;
      end
    end
    return res;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) rep_expect.push_back(rep_predict(timestamp_us, accel_z));
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
          next_sample = sample_queue.pop_front();
          in_valid <= 1'b1;
          timestamp_us <= next_sample.stamp;
          accel_z <= next_sample.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rep_expect.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result item with no sample waiting: counted %0b", counted);
        end else begin
          want = rep_expect.pop_front();
          if (counted !== want.counted || rep_count !== want.reps ||
              cycle_time_us !== want.cycle || min_z !== want.minimum) begin
            errors++;
            if (errors <= 10)
              $display("result differs: counted %0b/%0b reps %0d/%0d cycle %0d/%0d min %0d/%0d",
                       want.counted, counted, want.reps, rep_count,
                       want.cycle, cycle_time_us, want.minimum, min_z);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("accel_minimum_rep_counter_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic [TW-1:0] t, input logic signed [Z_WIDTH-1:0] z);
    sample_queue.push_back('{t, z});
  endtask

  // wait until every sample went in and every result came out
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || rep_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MINIMA_WINDOW:     window_us = val;
      REG_MIN_CYCLE:         least_gap = val;
      REG_REBOUND_THRESHOLD: rebound = val[THR_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // triangle wave of repetitions with noise on top
  task automatic push_wave(input int n);
    int period;
    int amp;
    int base;
    int noise;
    int dt;
    int phase0;
    int pos;
    int ramp;
    int z;
    period = $urandom_range(12, 40);
    amp = $urandom_range(1000, 16000);
    base = int'($urandom_range(0, 8000)) - 4000;
    noise = $urandom_range(0, 600);
    dt = $urandom_range(20000, 90000);
    phase0 = $urandom_range(0, period - 1);
    for (int k = 0; k < n; k++) begin
      pos = (k + phase0) % period;
      ramp = (2 * pos >= period) ? 2 * pos - period : period - 2 * pos;
      ramp = ramp * 2 * amp / period - amp;
      z = base + ramp + int'($urandom_range(0, 2 * noise)) - noise;
      if (z > 32767) z = 32767;
      if (z < -32768) z = -32768;
      stamp = stamp + dt + $urandom_range(0, dt / 4);
      push_sample(stamp, z[Z_WIDTH-1:0]);
    end
  endtask

  // full-range values, plateaus, backward steps and huge jumps
  task automatic push_noise(input int n);
    int r;
    logic signed [Z_WIDTH-1:0] z;
    z = '0;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r >= 20) z = Z_WIDTH'($urandom);
      if (r < 5) stamp = stamp - $urandom_range(0, 1000000);
      else if (r < 10) stamp = stamp + TW'({$urandom, $urandom});
      else stamp = stamp + $urandom_range(0, 2000000);
      push_sample(stamp, z);
    end
  endtask

  task automatic push_mix(input int n);
    int left;
    int len;
    left = n;
    while (left > 0) begin
      len = $urandom_range(20, 80);
      if (len > left) len = left;
      if ($urandom_range(99) < 80) push_wave(len);
      else push_noise(len);
      left -= len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: window fill, extremes, a reference then a count, plateau,
    // top timestamp and a backward step
    push_sample(48'd0, 16'sd0);
    push_sample(48'd100000, -16'sd32768);
    push_sample(48'd200000, 16'sd32767);
    push_sample(48'd300000, 16'sd32767);
    push_sample(48'd400000, 16'sd0);
    push_sample(48'd1500000, -16'sd32768);
    push_sample(48'd1600000, 16'sd0);
    push_sample(48'd1700000, 16'sd32767);
    push_sample(48'd1800000, 16'sd32767);
    push_sample(48'd2700000, -16'sd100);
    push_sample(48'd2800000, -16'sd20000);
    push_sample(48'd2900000, 16'sd5000);
    push_sample(48'd3000000, 16'sd5000);
    push_sample(48'd3100000, 16'sd5000);
    push_sample(48'd3200000, 16'sd9000);
    push_sample(48'd4500000, -16'sd25000);
    push_sample(48'd4600000, 16'sd9000);
    push_sample(48'hFFFF_FFFF_FFFF, -16'sd5);
    push_sample(48'd10, -16'sd30000);
    push_sample(48'd20, 16'sd100);
    push_sample(48'd2000000, -16'sd1);
    push_sample(48'd2000100, 16'sd0);
    stamp = 48'd2000100;
    drain();

    // defaults, with a long receiver hold while samples keep coming
    push_mix(120);
    hold_req <= hold_req + 1;
    drain();
    push_mix(130);
    drain();

    // everything counts; no idling on either side
    write_reg(REG_MINIMA_WINDOW, 32'd0);
    write_reg(REG_MIN_CYCLE, 32'd0);
    write_reg(REG_REBOUND_THRESHOLD, 32'd0);
    calm <= 1'b1;
    push_mix(200);
    drain();
    calm <= 1'b0;

    // upper extremes; threshold data carries bits above its width
    write_reg(REG_MINIMA_WINDOW, 32'hFFFF_FFFF);
    write_reg(REG_MIN_CYCLE, 32'hFFFF_FFFF);
    write_reg(REG_REBOUND_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(REG_NONE_FIRST, 32'h0000_0001);
    write_reg(REG_NONE_LAST, 32'hFFFF_FFFF);
    push_noise(60);
    drain();
    write_reg(REG_REBOUND_THRESHOLD, 32'h0);
    push_noise(90);
    drain();

    // random settings around the useful range
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_MINIMA_WINDOW, $urandom_range(200000, 2000000));
      write_reg(REG_MIN_CYCLE, $urandom_range(0, 2000000));
      write_reg(REG_REBOUND_THRESHOLD, {16'($urandom), 16'($urandom_range(0, 9000))});
      push_mix(130);
      drain();
    end

    if (errors == 0 && rep_expect.size() == 0) begin
      $display("accel_minimum_rep_counter_unit: match");
    end else begin
      $display("accel_minimum_rep_counter_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/amrc_pkg.sv
rtl/amrc_skid.sv
rtl/amrc_core.sv
rtl/accel_minimum_rep_counter_unit.sv
dv/accel_minimum_rep_counter_unit_tb.sv
